// ----- src/ellipse_fit_error_counter_top_macros.svh -----
// ----------------------------------------------------------------------------
// ellipse fit error counter assertion macros
// shared helpers for the concurrent checks of the top level
// ----------------------------------------------------------------------------
`ifndef ELLIPSE_FIT_ERROR_COUNTER_TOP_MACROS_SVH
`define ELLIPSE_FIT_ERROR_COUNTER_TOP_MACROS_SVH

// same-cycle implication
`define EFE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("efe check failed");

// next-cycle implication
`define EFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("efe check failed");

`endif

// ----- src/efe_pkg.sv -----
// ----------------------------------------------------------------------------
// efe_pkg
// types and constants shared by the ellipse fit error counter
// ----------------------------------------------------------------------------
package efe_pkg;

  localparam int FEATURES  = 4096;
  localparam int FEAT_AW   = $clog2(FEATURES);
  localparam int DIM_W     = 13;
  localparam int POS_W     = 12;
  localparam int CNT_W     = 25;
  localparam int RATIO_W   = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] DIM_MAX   = 13'd4096;
  localparam logic [DIM_W-1:0] DIM_RESET = 13'd256;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic [RATIO_W-1:0] RATIO_ONE = 17'd65536;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [11:0]        feature_index;
    logic [19:0]        center_x;
    logic [19:0]        center_y;
    logic signed [15:0] cos_angle;
    logic signed [15:0] sin_angle;
    logic [31:0]        semi_a_sq;
    logic [31:0]        semi_b_sq;
    logic [24:0]        cell_count;
  } in_t;

  typedef struct packed {
    logic [11:0] report_index;
    logic [24:0] outside_total;
    logic [24:0] inside_total;
    logic [16:0] error_ratio;
    logic        count_invalid;
  } out_t;

  typedef struct packed {
    logic [19:0]        cx;
    logic [19:0]        cy;
    logic signed [15:0] cs;
    logic signed [15:0] sn;
    logic [31:0]        a2;
    logic [31:0]        b2;
  } ell_t;

  typedef struct packed {
    logic [CNT_W-1:0] outside;
    logic [CNT_W-1:0] inner;
  } cnt_t;

  typedef struct packed {
    logic done;
    logic hit;
  } tst_res_t;

  typedef struct packed {
    logic               done;
    logic [RATIO_W-1:0] ratio;
    logic               invalid;
  } div_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_TEST,
    ST_REP_RD,
    ST_REP_DIV
  } state_t;

endpackage

// ----- src/efe_ram.sv -----
// ----------------------------------------------------------------------------
// efe_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module efe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/efe_test.sv -----
// ----------------------------------------------------------------------------
// efe_test
// seven stage pipeline that tests a pixel against a rotated ellipse
// ----------------------------------------------------------------------------
module efe_test
  import efe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [POS_W-1:0] px,
  input  logic [POS_W-1:0] py,
  input  ell_t             ell,
  output tst_res_t         res
);

  logic [6:0] vld_r;

  logic signed [21:0] dx_r, dy_r;
  logic signed [15:0] cs_r, sn_r;
  logic [31:0] a2_1_r, b2_1_r, a2_2_r, b2_2_r, a2_3_r, b2_3_r, a2_4_r, b2_4_r;

  logic signed [37:0] p_xc_r, p_xs_r, p_yc_r, p_ys_r;
  logic [63:0] ab_2_r, ab_3_r, ab_4_r, ab_5_r, ab_6_r;

  logic signed [38:0] u_nxt, v_nxt;
  logic [38:0] mag_u, mag_v, rnd_u, rnd_v;
  logic [31:0] mu_r, mv_r;

  logic [63:0] su_r, sv_r;
  logic [63:0] pl_u_r, ph_u_r, pl_v_r, ph_v_r;
  logic [96:0] lhs_r;
  logic        inside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], start};
    end
  end

  always_comb begin
    u_nxt = $signed({p_xc_r[37], p_xc_r}) - $signed({p_ys_r[37], p_ys_r});
    v_nxt = $signed({p_xs_r[37], p_xs_r}) + $signed({p_yc_r[37], p_yc_r});
    mag_u = u_nxt[38] ? 39'(-u_nxt) : 39'(u_nxt);
    mag_v = v_nxt[38] ? 39'(-v_nxt) : 39'(v_nxt);
    rnd_u = mag_u + 39'd32;
    rnd_v = mag_v + 39'd32;
  end

  always_ff @(posedge clk) begin
    // offset from center
    dx_r   <= $signed({2'b00, px, 8'h00}) - $signed({2'b00, ell.cx});
    dy_r   <= $signed({2'b00, py, 8'h00}) - $signed({2'b00, ell.cy});
    cs_r   <= ell.cs;
    sn_r   <= ell.sn;
    a2_1_r <= ell.a2;
    b2_1_r <= ell.b2;
    // rotation products
    p_xc_r <= dx_r * cs_r;
    p_xs_r <= dx_r * sn_r;
    p_yc_r <= dy_r * cs_r;
    p_ys_r <= dy_r * sn_r;
    ab_2_r <= a2_1_r * b2_1_r;
    a2_2_r <= a2_1_r;
    b2_2_r <= b2_1_r;
    // round to q.16
    mu_r   <= rnd_u[37:6];
    mv_r   <= rnd_v[37:6];
    ab_3_r <= ab_2_r;
    a2_3_r <= a2_2_r;
    b2_3_r <= b2_2_r;
    // squares
    su_r   <= mu_r * mu_r;
    sv_r   <= mv_r * mv_r;
    ab_4_r <= ab_3_r;
    a2_4_r <= a2_3_r;
    b2_4_r <= b2_3_r;
    // partial products against the axes
    pl_u_r <= su_r[31:0] * b2_4_r;
    ph_u_r <= su_r[63:32] * b2_4_r;
    pl_v_r <= sv_r[31:0] * a2_4_r;
    ph_v_r <= sv_r[63:32] * a2_4_r;
    ab_5_r <= ab_4_r;
    // sum
    lhs_r  <= {33'd0, pl_u_r} + {1'b0, ph_u_r, 32'd0}
            + {33'd0, pl_v_r} + {1'b0, ph_v_r, 32'd0};
    ab_6_r <= ab_5_r;
    // compare
    inside_r <= lhs_r < {9'd0, ab_6_r, 24'd0};
  end

  assign res.done = vld_r[6];
  assign res.hit  = inside_r;

endmodule

// ----- src/efe_ratio.sv -----
// ----------------------------------------------------------------------------
// efe_ratio
// radix-2 divider for the outside fraction, one quotient bit a cycle
// ----------------------------------------------------------------------------
module efe_ratio
  import efe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] outside,
  input  logic [CNT_W-1:0] cells,
  output div_res_t         res
);

  logic               run_r;
  logic [3:0]         cnt_r;
  logic [CNT_W-1:0]   rem_r;
  logic [CNT_W-1:0]   cells_r;
  logic [15:0]        q_r;
  logic               done_r;
  logic [RATIO_W-1:0] ratio_r;
  logic               invalid_r;

  logic [CNT_W:0]   rem2;
  logic             take;
  logic [CNT_W-1:0] rem_nxt;
  logic [15:0]      q_nxt;

  always_comb begin
    rem2    = {rem_r, 1'b0};
    take    = rem2 >= {1'b0, cells_r};
    rem_nxt = take ? CNT_W'(rem2 - {1'b0, cells_r}) : rem2[CNT_W-1:0];
    q_nxt   = {q_r[14:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (cells == '0 || outside >= cells) begin
          done_r <= 1'b1;
        end else begin
          run_r <= 1'b1;
        end
      end else if (run_r && cnt_r == 4'd15) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r     <= outside;
      cells_r   <= cells;
      cnt_r     <= '0;
      q_r       <= '0;
      ratio_r   <= RATIO_ONE;
      invalid_r <= (cells == '0);
    end else if (run_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        ratio_r <= {1'b0, q_nxt};
      end
    end
  end

  assign res.done    = done_r;
  assign res.ratio   = ratio_r;
  assign res.invalid = invalid_r;

endmodule

// ----- src/ellipse_fit_error_counter_top.sv -----
// ----------------------------------------------------------------------------
// ellipse_fit_error_counter_top
// per-feature count of raster pixels inside and outside an ideal ellipse
// ----------------------------------------------------------------------------
// After reset all 4096 counter memory entries are cleared with busy high.
// A load leaves busy low. A pixel with a non-zero label holds busy through
// the memory read, the seven stage ellipse test and the count write-back;
// a pixel with label 0 leaves busy low. A report holds busy through the
// counter read and the divider, which ends at once when the ratio is
// trivial and otherwise makes one quotient bit a cycle. The report appears
// on out_data for a single cycle with out_valid high and cannot be held off.
`include "ellipse_fit_error_counter_top_macros.svh"

module ellipse_fit_error_counter_top
  import efe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  in_data,
  output logic                 out_valid,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  state_t state_r, state_nxt;

  logic [FEAT_AW-1:0] clr_addr_r;
  logic [DIM_W-1:0]   width_r, height_r, dim_clamp;
  logic [POS_W-1:0]   raster_x_r, raster_y_r, px_r, py_r;
  logic [DIM_W-1:0]   x_inc, y_inc;
  in_t                item_r;
  out_t               out_r;
  logic               out_valid_r;

  logic               accept, cfg_wr;
  logic               pwe, pre, cwe, cre, tst_start, div_start;
  logic [FEAT_AW-1:0] caddr;
  cnt_t               cdata, crd, cnt_new;
  ell_t               pwdata, prd;
  tst_res_t           tst;
  div_res_t           div;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign pwdata.cx = in_data.center_x;
  assign pwdata.cy = in_data.center_y;
  assign pwdata.cs = in_data.cos_angle;
  assign pwdata.sn = in_data.sin_angle;
  assign pwdata.a2 = in_data.semi_a_sq;
  assign pwdata.b2 = in_data.semi_b_sq;

  efe_ram #(.WIDTH($bits(ell_t)), .DEPTH(FEATURES)) u_ell_ram (
    .clk   (clk),
    .we    (pwe),
    .waddr (in_data.feature_index[FEAT_AW-1:0]),
    .wdata (pwdata),
    .re    (pre),
    .raddr (in_data.feature_index[FEAT_AW-1:0]),
    .rdata (prd)
  );

  efe_ram #(.WIDTH($bits(cnt_t)), .DEPTH(FEATURES)) u_cnt_ram (
    .clk   (clk),
    .we    (cwe),
    .waddr (caddr),
    .wdata (cdata),
    .re    (cre),
    .raddr (in_data.feature_index[FEAT_AW-1:0]),
    .rdata (crd)
  );

  efe_test u_test (
    .clk   (clk),
    .rst_n (rst_n),
    .start (tst_start),
    .px    (px_r),
    .py    (py_r),
    .ell   (prd),
    .res   (tst)
  );

  efe_ratio u_ratio (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .outside (crd.outside),
    .cells   (item_r.cell_count),
    .res     (div)
  );

  always_comb begin
    cnt_new = crd;
    if (tst.hit) begin
      if (crd.inner != CNT_MAX) cnt_new.inner = crd.inner + 1'b1;
    end else begin
      if (crd.outside != CNT_MAX) cnt_new.outside = crd.outside + 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pwe       = 1'b0;
    pre       = 1'b0;
    cwe       = 1'b0;
    cre       = 1'b0;
    caddr     = in_data.feature_index[FEAT_AW-1:0];
    cdata     = '0;
    tst_start = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cwe   = 1'b1;
        caddr = clr_addr_r;
        if (clr_addr_r == FEAT_AW'(FEATURES - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data.kind)
            KIND_LOAD: begin
              pwe = 1'b1;
              cwe = 1'b1;
            end
            KIND_PIXEL: begin
              if (in_data.feature_index != '0) begin
                pre       = 1'b1;
                cre       = 1'b1;
                state_nxt = ST_PIX_RD;
              end
            end
            KIND_REPORT: begin
              cre       = 1'b1;
              state_nxt = ST_REP_RD;
            end
            default: ;
          endcase
        end
      end
      ST_PIX_RD: begin
        tst_start = 1'b1;
        state_nxt = ST_PIX_TEST;
      end
      ST_PIX_TEST: begin
        if (tst.done) begin
          cwe       = 1'b1;
          caddr     = item_r.feature_index[FEAT_AW-1:0];
          cdata     = cnt_new;
          state_nxt = ST_IDLE;
        end
      end
      ST_REP_RD: begin
        div_start = 1'b1;
        state_nxt = ST_REP_DIV;
      end
      ST_REP_DIV: begin
        if (div.done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    if (cfg_data == '0) dim_clamp = 13'd1;
    else if (cfg_data > DIM_MAX) dim_clamp = DIM_MAX;
    else dim_clamp = cfg_data;
    x_inc = {1'b0, raster_x_r} + 13'd1;
    y_inc = {1'b0, raster_y_r} + 13'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      width_r     <= DIM_RESET;
      height_r    <= DIM_RESET;
      raster_x_r  <= '0;
      raster_y_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
      out_valid_r <= (state_r == ST_REP_DIV) && div.done;
      if (cfg_wr && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT)) begin
        if (cfg_index == REG_WIDTH) width_r <= dim_clamp;
        else height_r <= dim_clamp;
        raster_x_r <= '0;
        raster_y_r <= '0;
      end else if (accept && in_data.kind == KIND_PIXEL) begin
        if (x_inc >= width_r) begin
          raster_x_r <= '0;
          raster_y_r <= (y_inc >= height_r) ? '0 : y_inc[POS_W-1:0];
        end else begin
          raster_x_r <= x_inc[POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
      px_r   <= raster_x_r;
      py_r   <= raster_y_r;
    end
    if (state_r == ST_REP_DIV && div.done) begin
      out_r.report_index  <= item_r.feature_index;
      out_r.outside_total <= crd.outside;
      out_r.inside_total  <= crd.inner;
      out_r.error_ratio   <= div.ratio;
      out_r.count_invalid <= div.invalid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `EFE_ASSERT_NEXT(a_out_after_div, (state_r == ST_REP_DIV) && div.done, out_valid)
  `EFE_ASSERT_NOW(a_out_only_report, out_valid, $past(state_r) == ST_REP_DIV)
  `EFE_ASSERT_NOW(a_test_done_state, tst.done, state_r == ST_PIX_TEST)
  `EFE_ASSERT_NEXT(a_report_enters, accept && in_data.kind == KIND_REPORT, state_r == ST_REP_RD)

endmodule
